### rtl/prq_pkg.sv
// Shared constants, types and helper functions for the packet ring queue.
package prq_pkg;

  localparam int SLOTS            = 8;
  localparam int BUF_BYTES        = 64;
  localparam int MIN_PACKET_BYTES = 5;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int IDX_W    = $clog2(BUF_BYTES);
  localparam int CNT_W    = $clog2(BUF_BYTES + 2);
  localparam int STORE_D  = SLOTS * BUF_BYTES;
  localparam int STORE_AW = $clog2(STORE_D);
  localparam int HELD_W   = SLOT_W + 4;

  typedef enum logic [2:0] {
    ST_TAKEN  = 3'd0,
    ST_COMMIT = 3'd1,
    ST_REJECT = 3'd2,
    ST_POPPED = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic       end_of_packet;
    logic [3:0] packet_count;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop_begin;
    logic pop_empty;
    logic len_load;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_last;
  } dp_status_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prq_ctrl.sv
// Controller state machine that sequences push, empty pop and streaming pop requests.
module prq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                action,
  input  prq_pkg::dp_status_t st,
  output prq_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_RUN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (action == prq_pkg::ACT_PUSH) begin
            cmd.push = 1'b1;
          end else if (st.empty) begin
            cmd.pop_empty = 1'b1;
          end else begin
            cmd.pop_begin = 1'b1;
            state_next    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.len_load = 1'b1;
        cmd.issue    = 1'b1;
        state_next   = st.idx_last ? S_IDLE : S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (st.idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_fetch_to_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_RUN))
    else $error("Fetch state was not followed by the streaming state.");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && st.idx_last) |=> (state == S_IDLE))
    else $error("Streaming did not stop after the final byte.");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("Busy flag disagrees with the controller state.");
`endif

endmodule

### rtl/prq_dpath.sv
// Datapath holding the ring pointers, the packet store and the result registers.
module prq_dpath (
  input  logic                clk,
  input  logic                rst,
  input  prq_pkg::ctrl_cmd_t  cmd,
  input  prq_pkg::req_t       req,
  output prq_pkg::dp_status_t st,
  output logic                strobe,
  output prq_pkg::res_t       res
);

  logic [prq_pkg::SLOT_W-1:0]   write_slot, write_slot_next;
  logic [prq_pkg::SLOT_W-1:0]   read_slot, read_slot_next;
  logic [prq_pkg::SLOT_W-1:0]   read_after_discard, write_slot_inc, pop_slot;
  logic                         full_flag, full_flag_next, full_after_discard;
  logic [prq_pkg::CNT_W-1:0]    push_byte_count, push_byte_count_next, count_inc;
  logic [prq_pkg::CNT_W-1:0]    pop_len, len_rdata;
  logic [prq_pkg::IDX_W-1:0]    idx, out_idx;
  logic                         pop_q, strobe_q, commit_ok, store_we;
  prq_pkg::status_t             status_q, push_status;
  logic [prq_pkg::STORE_AW-1:0] store_waddr, store_raddr;
  logic [7:0]                   store_rdata;
  logic [prq_pkg::HELD_W-1:0]   held;

  always_comb begin
    read_after_discard = read_slot;
    full_after_discard = full_flag;
    if (push_byte_count == '0 && full_flag) begin
      read_after_discard = prq_pkg::next_slot(read_slot);
      full_after_discard = 1'b0;
    end
    count_inc = (push_byte_count <= prq_pkg::CNT_W'(prq_pkg::BUF_BYTES))
              ? push_byte_count + 1'b1 : push_byte_count;
    commit_ok = req.last
              && count_inc >= prq_pkg::CNT_W'(prq_pkg::MIN_PACKET_BYTES)
              && count_inc <= prq_pkg::CNT_W'(prq_pkg::BUF_BYTES);
    write_slot_inc = prq_pkg::next_slot(write_slot);

    if (!req.last) begin
      push_status = prq_pkg::ST_TAKEN;
    end else if (commit_ok) begin
      push_status = prq_pkg::ST_COMMIT;
    end else begin
      push_status = prq_pkg::ST_REJECT;
    end

    write_slot_next      = write_slot;
    read_slot_next       = read_slot;
    full_flag_next       = full_flag;
    push_byte_count_next = push_byte_count;
    if (cmd.push) begin
      read_slot_next       = read_after_discard;
      full_flag_next       = full_after_discard;
      push_byte_count_next = req.last ? '0 : count_inc;
      if (commit_ok) begin
        write_slot_next = write_slot_inc;
        full_flag_next  = (write_slot_inc == read_after_discard);
      end
    end else if (cmd.pop_begin) begin
      read_slot_next = prq_pkg::next_slot(read_slot);
      full_flag_next = 1'b0;
    end
  end

  assign store_we    = cmd.push && (push_byte_count < prq_pkg::CNT_W'(prq_pkg::BUF_BYTES));
  assign store_waddr = prq_pkg::STORE_AW'(write_slot) * prq_pkg::STORE_AW'(prq_pkg::BUF_BYTES)
                     + prq_pkg::STORE_AW'(push_byte_count[prq_pkg::IDX_W-1:0]);
  assign store_raddr = prq_pkg::STORE_AW'(pop_slot) * prq_pkg::STORE_AW'(prq_pkg::BUF_BYTES)
                     + prq_pkg::STORE_AW'(idx);

  prq_ram #(
    .WIDTH (8),
    .DEPTH (prq_pkg::STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (req.data_byte),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  prq_ram #(
    .WIDTH (prq_pkg::CNT_W),
    .DEPTH (prq_pkg::SLOTS)
  ) u_length (
    .clk   (clk),
    .we    (cmd.push && commit_ok),
    .waddr (write_slot),
    .wdata (count_inc),
    .raddr (read_slot),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      read_slot       <= '0;
      full_flag       <= 1'b0;
      push_byte_count <= '0;
      strobe_q        <= 1'b0;
      pop_q           <= 1'b0;
      idx             <= '0;
    end else begin
      write_slot      <= write_slot_next;
      read_slot       <= read_slot_next;
      full_flag       <= full_flag_next;
      push_byte_count <= push_byte_count_next;
      strobe_q        <= cmd.push || cmd.pop_empty || cmd.issue;
      pop_q           <= cmd.issue;
      if (cmd.pop_begin) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_idx <= idx;
    if (cmd.issue) begin
      status_q <= prq_pkg::ST_POPPED;
    end else if (cmd.pop_empty) begin
      status_q <= prq_pkg::ST_EMPTY;
    end else begin
      status_q <= push_status;
    end
    if (cmd.pop_begin) begin
      pop_slot <= read_slot;
    end
    if (cmd.len_load) begin
      pop_len <= len_rdata;
    end
  end

  always_comb begin
    if (full_flag) begin
      held = prq_pkg::HELD_W'(prq_pkg::SLOTS);
    end else if (write_slot >= read_slot) begin
      held = prq_pkg::HELD_W'(write_slot) - prq_pkg::HELD_W'(read_slot);
    end else begin
      held = prq_pkg::HELD_W'(prq_pkg::SLOTS) + prq_pkg::HELD_W'(write_slot)
           - prq_pkg::HELD_W'(read_slot);
    end
  end

  assign strobe            = strobe_q;
  assign res.status        = status_q;
  assign res.data_out      = (pop_q && prq_pkg::CNT_W'(out_idx) < pop_len) ? store_rdata : 8'd0;
  assign res.end_of_packet = pop_q && (out_idx == prq_pkg::IDX_W'(prq_pkg::BUF_BYTES - 1));
  assign res.packet_count  = held[3:0];

  assign st.empty    = !full_flag && (read_slot == write_slot);
  assign st.idx_last = (idx == prq_pkg::IDX_W'(prq_pkg::BUF_BYTES - 1));

`ifndef SYNTHESIS
  a_full_pointers: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> (write_slot == read_slot))
    else $error("Queue marked full while the slot pointers differ.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    push_byte_count <= prq_pkg::CNT_W'(prq_pkg::BUF_BYTES + 1))
    else $error("Push byte count has passed its saturation value.");

  a_issue_result: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> (strobe && res.status == prq_pkg::ST_POPPED))
    else $error("A store read was not followed by a popped byte result.");
`endif

endmodule

### rtl/packet_ring_queue_overwrite.sv
// Top level of the packet ring queue that overwrites its oldest packet when full.
//
//   Channel   Ports                    Handshake
//   request   start, busy, request     taken at an edge with start high and busy low
//   result    strobe, result           valid for one cycle while strobe is high
//
// A push request's result appears in the cycle after it is taken; pushes may follow back to
// back. A pop of an empty queue behaves the same. A pop of a held packet keeps busy high until
// its last byte is read: the slot length is read at the accepting edge, then the store RAM
// gives one byte per cycle, each result in the cycle after its read, so the final byte appears
// in the first cycle with busy low again. Reset clears the pointers, the full flag and the byte
// count at once; the store needs no clearing. The receiver cannot stall results.
module packet_ring_queue_overwrite (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  prq_pkg::req_t   request,
  output logic            strobe,
  output prq_pkg::res_t   result
);

  prq_pkg::ctrl_cmd_t  cmd;
  prq_pkg::dp_status_t st;

  prq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (request.action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  prq_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (request),
    .st     (st),
    .strobe (strobe),
    .res    (result)
  );

endmodule

### sim/packet_ring_queue_overwrite_tb.sv
// Self-checking testbench for the packet ring queue that overwrites its oldest packet.
`timescale 1ns / 100ps

module packet_ring_queue_overwrite_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 14;

  typedef struct packed {
    prq_pkg::action_t act;
    logic [7:0]       first;
    logic [7:0]       nbytes;
    logic             term;
    logic [3:0]       times;
    logic             typed;
    prq_pkg::status_t st;
    logic [3:0]       cnt;
  } dir_row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  prq_pkg::req_t request;
  logic          strobe;
  prq_pkg::res_t result;

  logic          typed_check;
  prq_pkg::res_t typed_result;

  prq_pkg::res_t pending_results [$];
  int            accepted_count;
  int            sent_items;
  int            mismatches;
  int            cycles;
  int            sender_idle_pct;

  logic [7:0]    shadow_store [prq_pkg::SLOTS][prq_pkg::BUF_BYTES];
  int            shadow_len [prq_pkg::SLOTS];
  int            shadow_wr;
  int            shadow_rd;
  bit            shadow_full;
  int            shadow_bytes;
  bit            use_typed;
  prq_pkg::res_t typed_val;
  prq_pkg::res_t got;
  prq_pkg::res_t want;

  packet_ring_queue_overwrite dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int ring_advance(input int s);
    return (s + 1 >= prq_pkg::SLOTS) ? 0 : s + 1;
  endfunction

  function automatic int packets_held();
    if (shadow_full) begin
      return prq_pkg::SLOTS;
    end
    if (shadow_wr >= shadow_rd) begin
      return shadow_wr - shadow_rd;
    end
    return prq_pkg::SLOTS + shadow_wr - shadow_rd;
  endfunction

  task automatic post_result(input prq_pkg::status_t st, input logic [7:0] d, input logic eop);
    prq_pkg::res_t e;
    e.status        = st;
    e.data_out      = d;
    e.end_of_packet = eop;
    e.packet_count  = 4'(packets_held());
    if (use_typed) begin
      pending_results.push_back(typed_val);
    end else begin
      pending_results.push_back(e);
    end
  endtask

  task automatic predict_ring_step(input prq_pkg::req_t r);
    int slot;
    int len;
    if (r.action == prq_pkg::ACT_PUSH) begin
      if (shadow_bytes == 0 && shadow_full) begin
        shadow_rd   = ring_advance(shadow_rd);
        shadow_full = 1'b0;
      end
      if (shadow_bytes < prq_pkg::BUF_BYTES) begin
        shadow_store[shadow_wr][shadow_bytes] = r.data_byte;
      end
      if (shadow_bytes <= prq_pkg::BUF_BYTES) begin
        shadow_bytes++;
      end
      if (!r.last) begin
        post_result(prq_pkg::ST_TAKEN, 8'h00, 1'b0);
      end else if (shadow_bytes >= prq_pkg::MIN_PACKET_BYTES
                   && shadow_bytes <= prq_pkg::BUF_BYTES) begin
        shadow_len[shadow_wr] = shadow_bytes;
        shadow_wr = ring_advance(shadow_wr);
        if (shadow_wr == shadow_rd) begin
          shadow_full = 1'b1;
        end
        shadow_bytes = 0;
        post_result(prq_pkg::ST_COMMIT, 8'h00, 1'b0);
      end else begin
        shadow_bytes = 0;
        post_result(prq_pkg::ST_REJECT, 8'h00, 1'b0);
      end
    end else if (!shadow_full && shadow_rd == shadow_wr) begin
      post_result(prq_pkg::ST_EMPTY, 8'h00, 1'b0);
    end else begin
      slot        = shadow_rd;
      len         = shadow_len[slot];
      shadow_rd   = ring_advance(shadow_rd);
      shadow_full = 1'b0;
      for (int i = 0; i < prq_pkg::BUF_BYTES; i++) begin
        post_result(prq_pkg::ST_POPPED, (i < len) ? shadow_store[slot][i] : 8'h00,
                    i == prq_pkg::BUF_BYTES - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        got = result;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d data %02h eop %0d count %0d",
                   $time, got.status, got.data_out, got.end_of_packet, got.packet_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected status %0d data %02h eop %0d count %0d, got %0d %02h %0d %0d",
                     $time, want.status, want.data_out, want.end_of_packet, want.packet_count,
                     got.status, got.data_out, got.end_of_packet, got.packet_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        accepted_count++;
        use_typed = typed_check;
        typed_val = typed_result;
        predict_ring_step(request);
      end
    end
  end

  task automatic issue(input prq_pkg::req_t r, input logic chk, input prq_pkg::res_t tres);
    int seen;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    request      <= r;
    typed_check  <= chk;
    typed_result <= tres;
    seen = accepted_count;
    do @(negedge clk); while (accepted_count == seen);
    sent_items++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic dir_row_t directed_row(input int i);
    case (i)
      0:  return '{prq_pkg::ACT_POP,  8'h00, 8'd1,  1'b0, 4'd1, 1'b1, prq_pkg::ST_EMPTY,  4'd0};
      1:  return '{prq_pkg::ACT_PUSH, 8'hFD, 8'd5,  1'b1, 4'd1, 1'b1, prq_pkg::ST_COMMIT, 4'd1};
      2:  return '{prq_pkg::ACT_PUSH, 8'hAA, 8'd1,  1'b1, 4'd1, 1'b1, prq_pkg::ST_REJECT, 4'd1};
      3:  return '{prq_pkg::ACT_PUSH, 8'h10, 8'd4,  1'b1, 4'd1, 1'b1, prq_pkg::ST_REJECT, 4'd1};
      4:  return '{prq_pkg::ACT_PUSH, 8'h30, 8'd2,  1'b0, 4'd1, 1'b1, prq_pkg::ST_TAKEN,  4'd1};
      5:  return '{prq_pkg::ACT_POP,  8'h00, 8'd1,  1'b0, 4'd1, 1'b0, prq_pkg::ST_POPPED, 4'd0};
      6:  return '{prq_pkg::ACT_PUSH, 8'h40, 8'd3,  1'b1, 4'd1, 1'b1, prq_pkg::ST_COMMIT, 4'd1};
      7:  return '{prq_pkg::ACT_PUSH, 8'h80, 8'd64, 1'b1, 4'd1, 1'b1, prq_pkg::ST_COMMIT, 4'd2};
      8:  return '{prq_pkg::ACT_PUSH, 8'h00, 8'd70, 1'b1, 4'd1, 1'b1, prq_pkg::ST_REJECT, 4'd2};
      9:  return '{prq_pkg::ACT_PUSH, 8'h55, 8'd6,  1'b1, 4'd6, 1'b1, prq_pkg::ST_COMMIT, 4'd8};
      10: return '{prq_pkg::ACT_PUSH, 8'hC0, 8'd5,  1'b1, 4'd1, 1'b1, prq_pkg::ST_COMMIT, 4'd8};
      11: return '{prq_pkg::ACT_PUSH, 8'hE0, 8'd2,  1'b1, 4'd1, 1'b1, prq_pkg::ST_REJECT, 4'd7};
      12: return '{prq_pkg::ACT_POP,  8'h00, 8'd1,  1'b0, 4'd8, 1'b0, prq_pkg::ST_POPPED, 4'd0};
      default:
          return '{prq_pkg::ACT_POP,  8'h00, 8'd1,  1'b0, 4'd1, 1'b1, prq_pkg::ST_EMPTY,  4'd0};
    endcase
  endfunction

  task automatic random_phase(input int idle_pct, input int n_items);
    prq_pkg::req_t r;
    int            sel;
    int            len;
    int            stop_at;
    sender_idle_pct = idle_pct;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        r = '{prq_pkg::ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1))};
        issue(r, 1'b0, '0);
      end else if (sel < 30) begin
        r = '{prq_pkg::ACT_PUSH, 8'($urandom_range(255)), 1'($urandom_range(1))};
        issue(r, 1'b0, '0);
      end else begin
        sel = $urandom_range(99);
        if (sel < 65) begin
          len = $urandom_range(12, 5);
        end else if (sel < 75) begin
          len = $urandom_range(4, 1);
        end else if (sel < 85) begin
          len = $urandom_range(63, 13);
        end else if (sel < 92) begin
          len = prq_pkg::BUF_BYTES;
        end else begin
          len = $urandom_range(prq_pkg::BUF_BYTES + 6, prq_pkg::BUF_BYTES + 1);
        end
        for (int b = 0; b < len && sent_items < stop_at; b++) begin
          if ($urandom_range(99) < 3) begin
            r = '{prq_pkg::ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1))};
            issue(r, 1'b0, '0);
          end
          r = '{prq_pkg::ACT_PUSH, 8'($urandom_range(255)), b == len - 1};
          issue(r, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    dir_row_t      row;
    prq_pkg::req_t r;
    prq_pkg::res_t tres;
    logic          chk;
    rst             = 1'b1;
    start           = 1'b0;
    request         = '0;
    typed_check     = 1'b0;
    typed_result    = '0;
    accepted_count  = 0;
    sent_items      = 0;
    mismatches      = 0;
    cycles          = 0;
    sender_idle_pct = 10;
    shadow_wr       = 0;
    shadow_rd       = 0;
    shadow_full     = 1'b0;
    shadow_bytes    = 0;
    for (int s = 0; s < prq_pkg::SLOTS; s++) begin
      shadow_len[s] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row  = directed_row(i);
      tres = '{row.st, 8'h00, 1'b0, row.cnt};
      for (int t = 0; t < row.times; t++) begin
        if (row.act == prq_pkg::ACT_POP) begin
          r   = '{prq_pkg::ACT_POP, 8'h00, 1'b0};
          chk = row.typed && t == row.times - 1;
          issue(r, chk, tres);
        end else begin
          for (int b = 0; b < row.nbytes; b++) begin
            r   = '{prq_pkg::ACT_PUSH, row.first + 8'(b), row.term && b == row.nbytes - 1};
            chk = row.typed && t == row.times - 1 && b == row.nbytes - 1;
            issue(r, chk, tres);
          end
        end
      end
    end
    drain_results();

    random_phase(10, 20);
    drain_results();
    random_phase(57, 20);
    drain_results();
    random_phase(0, 17);
    drain_results();
    repeat (prq_pkg::BUF_BYTES + 4) @(negedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
